[design/sha1_message_digest_top_macros.svh]
// assertion helpers for the sha1 digest block
`ifndef SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH

// same-cycle implication
`define SHA1MD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1MD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sha1md_pkg.sv]
package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] hash_t;

  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  localparam hash_t HashInit = {32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE,
                                32'hEFCD_AB89, 32'h6745_2301};

  localparam logic [7:0] PadByte = 8'h80;
  localparam word_t      PadWord = {PadByte, 24'h00_0000};

  localparam logic [3:0] IdxLast     = 4'd15;
  localparam logic [3:0] IdxLenHi    = 4'd14;
  localparam logic [6:0] RndLast     = 7'd79;
  localparam logic [6:0] RndExpand   = 7'd16;
  localparam logic [2:0] FullBytes   = 3'd4;
  localparam logic [2:0] WordNumLast = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_PAD,
    PH_ZERO,
    PH_LO
  } pad_ph_t;

  typedef struct packed {
    logic push;
    logic step;
    logic expand;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic accum;
    logic reinit;
  } core_ctrl_t;

  function automatic word_t sha1md_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    priority if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t sha1md_k(logic [6:0] rnd);
    word_t k;
    priority if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  // keep the valid top bytes and place the pad byte right after them
  function automatic word_t sha1md_pad(word_t w, logic [1:0] cnt);
    word_t p;
    unique case (cnt)
      2'd0: p = PadWord;
      2'd1: p = {w[31:24], PadByte, 16'h0000};
      2'd2: p = {w[31:16], PadByte, 8'h00};
      2'd3: p = {w[31:8], PadByte};
    endcase
    return p;
  endfunction

endpackage

[design/sha1md_sched.sv]
module sha1md_sched (
  input  logic                     clk,
  input  sha1md_pkg::sched_ctrl_t  ctrl,
  input  sha1md_pkg::word_t        push_data,
  output sha1md_pkg::word_t        w_cur
);

  logic [15:0][31:0]  win_r;
  sha1md_pkg::word_t  w_mix;
  sha1md_pkg::word_t  w_exp;
  sha1md_pkg::word_t  shift_in;

  always_comb begin
    w_mix    = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    w_exp    = {w_mix[30:0], w_mix[31]};
    w_cur    = ctrl.expand ? w_exp : win_r[0];
    shift_in = ctrl.push ? push_data : w_cur;
  end

  // window shifts down, oldest word at entry 0
  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      win_r <= {shift_in, win_r[15:1]};
    end
  end

endmodule

[design/sha1md_core.sv]
module sha1md_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sha1md_pkg::core_ctrl_t  ctrl,
  input  logic [6:0]              rnd,
  input  sha1md_pkg::word_t       w,
  output sha1md_pkg::hash_t       hash
);

  sha1md_pkg::hash_t  hash_r;
  sha1md_pkg::hash_t  hash_nxt;
  sha1md_pkg::hash_t  wv_r;
  sha1md_pkg::hash_t  wv_nxt;
  sha1md_pkg::word_t  a_rot;
  sha1md_pkg::word_t  b_rot;
  sha1md_pkg::word_t  sum;

  // one round through the shared adder
  always_comb begin
    a_rot = {wv_r[0][26:0], wv_r[0][31:27]};
    b_rot = {wv_r[1][1:0], wv_r[1][31:2]};
    sum   = a_rot + sha1md_pkg::sha1md_f(rnd, wv_r[1], wv_r[2], wv_r[3])
          + wv_r[4] + sha1md_pkg::sha1md_k(rnd) + w;
  end

  always_comb begin
    wv_nxt = wv_r;
    if (ctrl.load) begin
      wv_nxt = hash_r;
    end else if (ctrl.step) begin
      wv_nxt = {wv_r[3], wv_r[2], b_rot, wv_r[0], sum};
    end
  end

  always_comb begin
    hash_nxt = hash_r;
    if (ctrl.reinit) begin
      hash_nxt = sha1md_pkg::HashInit;
    end else if (ctrl.accum) begin
      for (int i = 0; i < 5; i++) begin
        hash_nxt[i] = hash_r[i] + wv_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    wv_r <= wv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sha1md_pkg::HashInit;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

[design/sha1_message_digest_top.sv]
// sha1 digest, one message at a time, one round per cycle on a shared round adder
// input: a word that completes no block is taken without holding the input off; the 16th word of a block
//   holds the input off through the 80 rounds and the one hash add
// no words of a new block are taken until the previous block's rounds and hash add are done
// last item: padding words at 1 per cycle, one or two compressed blocks, then 5 digest words
// reset: synchronous active low, loads the initial hash and clears all counts
module sha1_message_digest_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // data_word
  input  logic [2:0]   in_tuser,   // byte_count
  input  logic         in_tlast,   // is_last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // digest_word
  output logic [2:0]   out_tuser,  // word_number
  output logic         out_tlast   // is_final_word
);

  sha1md_pkg::state_t       state_r, state_nxt;
  sha1md_pkg::state_t       ret_r, ret_nxt;
  sha1md_pkg::pad_ph_t      ph_r, ph_nxt;
  logic [3:0]               idx_r, idx_nxt;
  logic [6:0]               rnd_r, rnd_nxt;
  logic [63:0]              bits_r, bits_nxt;
  sha1md_pkg::word_t        pad_r, pad_nxt;
  logic [2:0]               wn_r, wn_nxt;

  logic                     in_acc;
  logic                     out_acc;
  logic [2:0]               cnt;
  logic                     cnt4;
  logic                     push;
  logic                     wrap;
  sha1md_pkg::word_t        push_data;
  sha1md_pkg::word_t        w_cur;
  sha1md_pkg::hash_t        hash;
  sha1md_pkg::sched_ctrl_t  sched_ctrl;
  sha1md_pkg::core_ctrl_t   core_ctrl;

  assign in_tready  = (state_r == sha1md_pkg::ST_IDLE);
  assign out_tvalid = (state_r == sha1md_pkg::ST_OUT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  assign cnt  = (in_tlast && (in_tuser < sha1md_pkg::FullBytes)) ? in_tuser
                                                                 : sha1md_pkg::FullBytes;
  assign cnt4 = (cnt == sha1md_pkg::FullBytes);

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_tlast) begin
            if (idx_r == sha1md_pkg::IdxLast) begin
              state_nxt = sha1md_pkg::ST_COMP;
              ret_nxt   = sha1md_pkg::ST_IDLE;
            end
          end else begin
            ph_nxt = sha1md_pkg::PH_PAD;
            if (cnt4 && (idx_r == sha1md_pkg::IdxLast)) begin
              state_nxt = sha1md_pkg::ST_COMP;
              ret_nxt   = sha1md_pkg::ST_PAD;
            end else begin
              state_nxt = sha1md_pkg::ST_PAD;
            end
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        unique case (ph_r)
          sha1md_pkg::PH_PAD:  ph_nxt = sha1md_pkg::PH_ZERO;
          sha1md_pkg::PH_ZERO: begin
            if (idx_r == sha1md_pkg::IdxLenHi) begin
              ph_nxt = sha1md_pkg::PH_LO;
            end
          end
          sha1md_pkg::PH_LO:   ph_nxt = sha1md_pkg::PH_PAD;
          default:             ph_nxt = sha1md_pkg::PH_PAD;
        endcase
        if (idx_r == sha1md_pkg::IdxLast) begin
          state_nxt = sha1md_pkg::ST_COMP;
          ret_nxt   = (ph_r == sha1md_pkg::PH_LO) ? sha1md_pkg::ST_OUT : sha1md_pkg::ST_PAD;
        end
      end
      sha1md_pkg::ST_COMP: begin
        if (rnd_r == sha1md_pkg::RndLast) begin
          state_nxt = sha1md_pkg::ST_ADD;
        end
      end
      sha1md_pkg::ST_ADD: state_nxt = ret_r;
      sha1md_pkg::ST_OUT: begin
        if (out_acc && (wn_r == sha1md_pkg::WordNumLast)) begin
          state_nxt = sha1md_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1md_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit control
  always_comb begin
    push      = 1'b0;
    push_data = in_tdata;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: push = in_acc && (!in_tlast || cnt4);
      sha1md_pkg::ST_PAD: begin
        push = 1'b1;
        unique case (ph_r)
          sha1md_pkg::PH_PAD:  push_data = pad_r;
          sha1md_pkg::PH_ZERO: push_data = (idx_r == sha1md_pkg::IdxLenHi) ? bits_r[63:32]
                                                                             : 32'h0000_0000;
          sha1md_pkg::PH_LO:   push_data = bits_r[31:0];
          default:             push_data = 32'h0000_0000;
        endcase
      end
      sha1md_pkg::ST_COMP,
      sha1md_pkg::ST_ADD,
      sha1md_pkg::ST_OUT:  push = 1'b0;
      default:             push = 1'b0;
    endcase
    wrap              = push && (idx_r == sha1md_pkg::IdxLast);
    sched_ctrl.push   = push;
    sched_ctrl.step   = (state_r == sha1md_pkg::ST_COMP);
    sched_ctrl.expand = (state_r == sha1md_pkg::ST_COMP) && (rnd_r >= sha1md_pkg::RndExpand);
    core_ctrl.load    = wrap;
    core_ctrl.step    = (state_r == sha1md_pkg::ST_COMP);
    core_ctrl.accum   = (state_r == sha1md_pkg::ST_ADD);
    core_ctrl.reinit  = out_acc && (wn_r == sha1md_pkg::WordNumLast);
    out_tdata         = hash[wn_r];
    out_tuser         = wn_r;
    out_tlast         = (wn_r == sha1md_pkg::WordNumLast);
  end

  // counters and length
  always_comb begin
    idx_nxt  = push ? idx_r + 4'd1 : idx_r;
    rnd_nxt  = rnd_r;
    bits_nxt = bits_r;
    pad_nxt  = pad_r;
    wn_nxt   = wn_r;
    if (state_r == sha1md_pkg::ST_COMP) begin
      rnd_nxt = (rnd_r == sha1md_pkg::RndLast) ? 7'd0 : rnd_r + 7'd1;
    end
    if (in_acc) begin
      bits_nxt = bits_r + {58'd0, cnt, 3'b000};
      pad_nxt  = cnt4 ? sha1md_pkg::PadWord : sha1md_pkg::sha1md_pad(in_tdata, cnt[1:0]);
    end
    if (out_acc) begin
      if (wn_r == sha1md_pkg::WordNumLast) begin
        wn_nxt   = 3'd0;
        bits_nxt = 64'd0;
      end else begin
        wn_nxt = wn_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1md_pkg::ST_IDLE;
      ret_r   <= sha1md_pkg::ST_IDLE;
      ph_r    <= sha1md_pkg::PH_PAD;
      idx_r   <= 4'd0;
      rnd_r   <= 7'd0;
      bits_r  <= 64'd0;
      wn_r    <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
      bits_r  <= bits_nxt;
      wn_r    <= wn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_r <= pad_nxt;
  end

  sha1md_sched u_sched (
    .clk       (clk),
    .ctrl      (sched_ctrl),
    .push_data (push_data),
    .w_cur     (w_cur)
  );

  sha1md_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (core_ctrl),
    .rnd   (rnd_r),
    .w     (w_cur),
    .hash  (hash)
  );

endmodule

[design/sha1md_checker.sv]
`include "sha1_message_digest_top_macros.svh"

module sha1md_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [31:0]  in_tdata,
  input logic [2:0]   in_tuser,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  `SHA1MD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled digest word changed")
  `SHA1MD_ASSERT_NOW(a_busy_out, out_tvalid, !in_tready, "input ready while digest words pending")
  `SHA1MD_ASSERT_NEXT(a_word_seq, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tuser == $past(out_tuser) + 3'd1), "digest words out of order")
  `SHA1MD_ASSERT_NOW(a_final_mark, out_tvalid, out_tlast == (out_tuser == 3'd4), "final word mark wrong")
  `SHA1MD_ASSERT_NEXT(a_pad_busy, in_tvalid && in_tready && in_tlast, !in_tready, "input ready right after last request")

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (.*);
